### hdl/sobel_edge_threshold_core_assert.svh
// Assertion macros for the Sobel edge threshold core checker.
// Included by the checker file only; no other dependencies.
`ifndef SOBEL_EDGE_THRESHOLD_CORE_ASSERT_SVH
`define SOBEL_EDGE_THRESHOLD_CORE_ASSERT_SVH

// Clocked property, switched off while reset is asserted (active low).
`define SET_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that also covers the reset cycles.
`define SET_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### hdl/sobel_et_pkg.sv
// Shared types and constants of the Sobel edge threshold core.
// No dependencies; every other design file and the checker refer to it by scope.
package sobel_et_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MIN_WIDTH      = 3;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 10;
    localparam int GRAD_W     = 11;
    localparam int SQ_W       = 20;
    localparam int MAG_W      = 21;
    localparam int THR2_W     = 22;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_INDEX_W = 1;

    localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(2080800);

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_THRESHOLD = 1'd1;

    localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST    = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] EDGE_THRESHOLD_RST = 11'd275;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             start_of_frame;
    } s_req_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_row;
        logic [COORD_W-1:0] center_col;
        logic [MAG_W-1:0]   magnitude_sq;
        logic               edge_res;
    } m_res_t;

    // One line buffer entry: the pixel two rows up and the one a row up.
    typedef struct packed {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
    } line_pair_t;

    // Newest window column, top to bottom.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } column_t;

    typedef struct packed {
        logic load_sq;
        logic load_out;
    } mag_ctl_t;

endpackage

### hdl/sobel_et_linebuf.sv
// Two line buffers packed in one synchronous RAM, one read and one write port.
// Read data is registered; a write to the address read in the same cycle is forwarded.
// Uses sobel_et_pkg.
module sobel_et_linebuf #(
    parameter int DEPTH = sobel_et_pkg::MAX_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           rd_en,
    input  logic [$clog2(DEPTH)-1:0]       rd_addr,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  sobel_et_pkg::line_pair_t       wr_data,
    output sobel_et_pkg::line_pair_t       rd_data
);

    sobel_et_pkg::line_pair_t mem [DEPTH];

    sobel_et_pkg::line_pair_t rd_raw_reg;
    sobel_et_pkg::line_pair_t byp_data_reg;
    logic                     byp_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read; the array returns old data on a collision.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_raw_reg   <= mem[rd_addr];
            byp_reg      <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_raw_reg;

endmodule

### hdl/sobel_et_grad.sv
// 3x3 window registers and the Sobel X and Y gradients of the shifted window.
// Uses sobel_et_pkg.
module sobel_et_grad (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     shift,
    input  sobel_et_pkg::column_t                    col_in,
    output logic signed [sobel_et_pkg::GRAD_W-1:0]   gx,
    output logic signed [sobel_et_pkg::GRAD_W-1:0]   gy
);

    localparam int PW = sobel_et_pkg::PIX_W;
    localparam int GW = sobel_et_pkg::GRAD_W;

    // win1 is the oldest kept column, win2 the one after it; rows top to bottom.
    logic [PW-1:0] win1_reg [3];
    logic [PW-1:0] win2_reg [3];
    logic [PW-1:0] newest   [3];

    logic [GW-2:0] right_sum, left_sum, bot_sum, top_sum;

    assign newest[0] = col_in.top;
    assign newest[1] = col_in.mid;
    assign newest[2] = col_in.bot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                win1_reg[r] <= '0;
                win2_reg[r] <= '0;
            end
        end else if (shift) begin
            for (int r = 0; r < 3; r++) begin
                win1_reg[r] <= win2_reg[r];
                win2_reg[r] <= newest[r];
            end
        end
    end

    // Kernel taps 1, 2, 1 along the edge columns and rows of the shifted window.
    always_comb begin
        right_sum = {2'b00, newest[0]} + {1'b0, newest[1], 1'b0} + {2'b00, newest[2]};
        left_sum  = {2'b00, win1_reg[0]} + {1'b0, win1_reg[1], 1'b0} + {2'b00, win1_reg[2]};
        bot_sum   = {2'b00, win1_reg[2]} + {1'b0, win2_reg[2], 1'b0} + {2'b00, newest[2]};
        top_sum   = {2'b00, win1_reg[0]} + {1'b0, win2_reg[0], 1'b0} + {2'b00, newest[0]};
        gx = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
        gy = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
    end

endmodule

### hdl/sobel_et_mag.sv
// Squared gradient magnitude and threshold compare, two register stages.
// Uses sobel_et_pkg.
module sobel_et_mag (
    input  logic                                          aclk,
    input  sobel_et_pkg::mag_ctl_t                        ctl,
    input  logic signed [sobel_et_pkg::GRAD_W-1:0]        gx,
    input  logic signed [sobel_et_pkg::GRAD_W-1:0]        gy,
    input  logic [sobel_et_pkg::CFG_DATA_W-1:0]           threshold,
    output logic [sobel_et_pkg::MAG_W-1:0]                magnitude_sq,
    output logic                                          edge_res
);

    localparam int GW  = sobel_et_pkg::GRAD_W;
    localparam int SW  = sobel_et_pkg::SQ_W;
    localparam int MW  = sobel_et_pkg::MAG_W;
    localparam int TW  = sobel_et_pkg::THR2_W;

    logic signed [2*GW-1:0] gx_sq_full, gy_sq_full;
    logic [SW-1:0]          gx_sq_reg, gy_sq_reg;
    logic [TW-1:0]          thr_ext, thr2_reg;
    logic [MW-1:0]          sum;
    logic [MW-1:0]          mag_reg;
    logic                   edge_reg;

    assign gx_sq_full = gx * gx;
    assign gy_sq_full = gy * gy;
    assign thr_ext    = TW'(threshold);

    // The user must change the threshold only while idle; not enforced here. Its square is refreshed every cycle.
    always_ff @(posedge aclk) begin
        thr2_reg <= thr_ext * thr_ext;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_sq) begin
            gx_sq_reg <= gx_sq_full[SW-1:0];
            gy_sq_reg <= gy_sq_full[SW-1:0];
        end
    end

    assign sum = {1'b0, gx_sq_reg} + {1'b0, gy_sq_reg};

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            mag_reg  <= sum;
            edge_reg <= TW'(sum) >= thr2_reg;
        end
    end

    assign magnitude_sq = mag_reg;
    assign edge_res     = edge_reg;

endmodule

### hdl/sobel_edge_threshold_core.sv
// Top level of the streaming 3x3 Sobel edge threshold core.
// Uses sobel_et_pkg, sobel_et_linebuf, sobel_et_grad and sobel_et_mag.
//
// Usage:
//   s_valid/s_ready/s_data carry gray pixels in raster order; start_of_frame
//   on a request restarts the row and column counters at that pixel.
//   m_valid/m_ready/m_data carry one result per pixel whose row and column
//   are both at least 2, describing the window centre one row up and one
//   column left. Border pixels give no result.
//   cfg_wr_en/cfg_wr_index/cfg_wr_data write image_width (index 0) and
//   edge_threshold (index 1); write them only while the core is idle.
//   Throughput: one pixel per clock while m_ready is high. Each pixel costs one
//   read and one write of the shared line buffer RAM, which are overlapped across pixels.
//   Pipeline: after a pixel's request is accepted, its result passes the RAM read,
//   gradient, square, and sum and compare registers before it is on m_data.
//   Reset: counters clear, registers return to 1024 and 275, the pipeline
//   empties. Line buffer contents are not cleared; the first two rows of a
//   frame refill them before any result depends on them.
//   Stall: when m_ready is low the result holds and the stages behind it fill;
//   s_ready drops only once every stage holding a result-bearing pixel is full.
//   Border pixels still drain through the line buffer stage.
module sobel_edge_threshold_core #(
    parameter int MAX_WIDTH  = sobel_et_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sobel_et_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  sobel_et_pkg::s_req_t                     s_data,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output sobel_et_pkg::m_res_t                     m_data,
    input  logic                                     cfg_wr_en,
    input  logic [sobel_et_pkg::CFG_INDEX_W-1:0]     cfg_wr_index,
    input  logic [sobel_et_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int DW  = sobel_et_pkg::CFG_DATA_W;
    localparam int EW  = (CW + 1 > DW) ? CW + 1 : DW;
    localparam int KW  = sobel_et_pkg::COORD_W;
    localparam int CXW = CW + KW;
    localparam int RXW = RW + KW;
    localparam int PW  = sobel_et_pkg::PIX_W;
    localparam int GW  = sobel_et_pkg::GRAD_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [DW-1:0] image_width_reg;
    logic [DW-1:0] edge_threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg    <= sobel_et_pkg::IMAGE_WIDTH_RST;
            edge_threshold_reg <= sobel_et_pkg::EDGE_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                sobel_et_pkg::REG_IMAGE_WIDTH:    image_width_reg    <= cfg_wr_data;
                sobel_et_pkg::REG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_wr_data;
                default:                          ;
            endcase
        end
    end

    // Clamp the programmed width into the range the line buffer supports.
    logic [EW-1:0] width_raw, width_eff;

    always_comb begin
        width_raw = EW'(image_width_reg);
        if (width_raw < EW'(sobel_et_pkg::MIN_WIDTH)) begin
            width_eff = EW'(sobel_et_pkg::MIN_WIDTH);
        end else if (width_raw > EW'(MAX_WIDTH)) begin
            width_eff = EW'(MAX_WIDTH);
        end else begin
            width_eff = width_raw;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline handshake: each stage advances when the next has room.
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic prod1_reg;
    logic rdy1, rdy2, rdy3, rdy4, leave1, acc;

    always_comb begin
        rdy4   = !v4_reg || m_ready;
        rdy3   = !v3_reg || rdy4;
        rdy2   = !v2_reg || rdy3;
        // Border pixels need no downstream room; they drop after stage 1.
        leave1 = v1_reg && (!prod1_reg || rdy2);
        rdy1   = !v1_reg || leave1;
    end

    assign s_ready = rdy1;
    assign acc     = s_valid && rdy1;

    // ---------------------------------------------------------------
    // Stage 0: position counters and line buffer read
    // ---------------------------------------------------------------
    logic [CW-1:0]  col_reg, col_cur, col_next;
    logic [RW-1:0]  row_reg, row_cur, row_next;
    logic           wrap, prod0;
    logic [RW-1:0]  row_m1;
    logic [CW-1:0]  col_m1;
    logic [RXW-1:0] row_ext;
    logic [CXW-1:0] col_ext;

    always_comb begin
        col_cur  = s_data.start_of_frame ? '0 : col_reg;
        row_cur  = s_data.start_of_frame ? '0 : row_reg;
        wrap     = (EW'(col_cur) + EW'(1)) >= width_eff;
        col_next = wrap ? '0 : col_cur + CW'(1);
        if (wrap && (row_cur < RW'(MAX_HEIGHT - 1))) begin
            row_next = row_cur + RW'(1);
        end else begin
            row_next = row_cur;
        end
        prod0   = (row_cur >= RW'(2)) && (col_cur >= CW'(2));
        row_m1  = row_cur - RW'(1);
        col_m1  = col_cur - CW'(1);
        row_ext = RXW'(row_m1);
        col_ext = CXW'(col_m1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (acc) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: line buffer data back, write back, window shift, gradients
    // ---------------------------------------------------------------
    logic [PW-1:0] px1_reg;
    logic [CW-1:0] addr1_reg;
    logic [KW-1:0] row1_reg, col1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            px1_reg   <= s_data.pixel;
            addr1_reg <= col_cur;
            prod1_reg <= prod0;
            row1_reg  <= row_ext[KW-1:0];
            col1_reg  <= col_ext[KW-1:0];
        end
    end

    sobel_et_pkg::line_pair_t lb_rd, lb_wr;
    sobel_et_pkg::column_t    column;

    // Shift the line pair down a row: the older line takes the newer one.
    assign lb_wr.older = lb_rd.newer;
    assign lb_wr.newer = px1_reg;

    assign column.top = lb_rd.older;
    assign column.mid = lb_rd.newer;
    assign column.bot = px1_reg;

    sobel_et_linebuf #(
        .DEPTH (MAX_WIDTH)
    ) u_linebuf (
        .aclk    (aclk),
        .rd_en   (acc),
        .rd_addr (col_cur),
        .wr_en   (leave1),
        .wr_addr (addr1_reg),
        .wr_data (lb_wr),
        .rd_data (lb_rd)
    );

    logic signed [GW-1:0] gx1, gy1;

    sobel_et_grad u_grad (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift   (leave1),
        .col_in  (column),
        .gx      (gx1),
        .gy      (gy1)
    );

    // ---------------------------------------------------------------
    // Stage 2: gradients registered
    // ---------------------------------------------------------------
    logic signed [GW-1:0] gx2_reg, gy2_reg;
    logic [KW-1:0]        row2_reg, col2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg && prod1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg && prod1_reg) begin
            gx2_reg  <= gx1;
            gy2_reg  <= gy1;
            row2_reg <= row1_reg;
            col2_reg <= col1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: squares; stage 4: sum, compare, output register
    // ---------------------------------------------------------------
    logic [KW-1:0] row3_reg, col3_reg, row4_reg, col4_reg;
    sobel_et_pkg::mag_ctl_t mag_ctl;

    assign mag_ctl.load_sq  = rdy3 && v2_reg;
    assign mag_ctl.load_out = rdy4 && v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mag_ctl.load_sq) begin
            row3_reg <= row2_reg;
            col3_reg <= col2_reg;
        end
        if (mag_ctl.load_out) begin
            row4_reg <= row3_reg;
            col4_reg <= col3_reg;
        end
    end

    logic [sobel_et_pkg::MAG_W-1:0] mag_out;
    logic                           edge_out;

    sobel_et_mag u_mag (
        .aclk         (aclk),
        .ctl          (mag_ctl),
        .gx           (gx2_reg),
        .gy           (gy2_reg),
        .threshold    (edge_threshold_reg),
        .magnitude_sq (mag_out),
        .edge_res     (edge_out)
    );

    assign m_valid             = v4_reg;
    assign m_data.center_row   = row4_reg;
    assign m_data.center_col   = col4_reg;
    assign m_data.magnitude_sq = mag_out;
    assign m_data.edge_res     = edge_out;

endmodule

### hdl/sobel_et_checker.sv
// Port-level checker for the Sobel edge threshold core, bound to the top level.
// Uses sobel_et_pkg and the macros of sobel_edge_threshold_core_assert.svh.
`include "sobel_edge_threshold_core_assert.svh"

module sobel_et_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input sobel_et_pkg::s_req_t                  s_data,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input sobel_et_pkg::m_res_t                  m_data,
    input logic                                  cfg_wr_en,
    input logic [sobel_et_pkg::CFG_INDEX_W-1:0]  cfg_wr_index,
    input logic [sobel_et_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    localparam int TW = sobel_et_pkg::THR2_W;

    logic [sobel_et_pkg::CFG_DATA_W-1:0] thr_shadow_reg;
    logic [TW-1:0]                       thr_ext, thr2;

    // Track the threshold as written through the config port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_shadow_reg <= sobel_et_pkg::EDGE_THRESHOLD_RST;
        end else if (cfg_wr_en && (cfg_wr_index == sobel_et_pkg::REG_EDGE_THRESHOLD)) begin
            thr_shadow_reg <= cfg_wr_data;
        end
    end

    assign thr_ext = TW'(thr_shadow_reg);
    assign thr2    = thr_ext * thr_ext;

    `SET_ASSERT_NORST(a_reset_empties, aclk, !aresetn |=> !m_valid, "result valid after reset")

    `SET_ASSERT(a_stall_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result changed")

    `SET_ASSERT(a_mag_range, aclk, aresetn, m_valid |-> m_data.magnitude_sq <= sobel_et_pkg::MAG_MAX, "magnitude out of range")

    `SET_ASSERT(a_edge_match, aclk, aresetn, m_valid |-> m_data.edge_res == (TW'(m_data.magnitude_sq) >= thr2), "edge bit disagrees with threshold")

    `SET_ASSERT(a_latency, aclk, aresetn, $rose(m_valid) |-> $past(s_valid && s_ready, 4), "result without request four cycles earlier")

endmodule

bind sobel_edge_threshold_core sobel_et_checker u_sobel_et_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_data       (s_data),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_data       (m_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_index (cfg_wr_index),
    .cfg_wr_data  (cfg_wr_data)
);
